// ----- rtl/dwnp_pkg.sv -----
// Shared types, codes and helpers of the depth window nearest pick block.
// Depends on nothing; the interfaces and the top level use it.
`default_nettype none

package dwnp_pkg;

  localparam int unsigned WINDOW_DEF = 15;
  localparam int unsigned COORD_W    = 13;
  localparam int unsigned DEPTH_W    = 24;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [DEPTH_W-1:0] DEPTH_EMPTY = '1;

  localparam logic [COORD_W-1:0] VP_WIDTH_RST  = COORD_W'(400);
  localparam logic [COORD_W-1:0] VP_HEIGHT_RST = COORD_W'(400);

  typedef enum logic {
    MODE_START  = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_t;

  typedef enum logic {
    KIND_ORIGIN = 1'b0,
    KIND_PICK   = 1'b1
  } kind_t;

  typedef enum logic {
    REG_VIEWPORT_WIDTH  = 1'b0,
    REG_VIEWPORT_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    mode_t              mode;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [DEPTH_W-1:0] depth_sample;
  } in_item_t;

  typedef struct packed {
    kind_t              result_kind;
    logic [COORD_W-1:0] window_x;
    logic [COORD_W-1:0] window_y;
    logic               found;
    logic [COORD_W-1:0] hit_x;
    logic [COORD_W-1:0] hit_y;
    logic [DEPTH_W-1:0] hit_depth;
  } out_item_t;

  // Window corner for a centre, clamped into [0, size-window], saturating at 0.
  function automatic logic [COORD_W-1:0] place_corner(
    input logic signed [14:0]  centre,
    input logic [COORD_W-1:0]  size,
    input logic [5:0]          half,
    input logic [6:0]          window
  );
    logic signed [14:0] c;
    logic signed [14:0] hi;
    c  = centre - $signed({9'b0, half});
    hi = $signed({2'b0, size}) - $signed({8'b0, window});
    if (c < 15'sd0) c = 15'sd0;
    if (c > hi) c = hi;
    if (c < 15'sd0) c = 15'sd0;
    return c[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dwnp_ifs.sv -----
// Valid/ready channel interfaces for request and result items.
// Depends on dwnp_pkg for the payload types.
`default_nettype none

interface dwnp_in_if;
  logic               valid;
  logic               ready;
  dwnp_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dwnp_out_if;
  logic                valid;
  logic                ready;
  dwnp_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/depth_window_nearest_pick.sv -----
// Depth window nearest pick: top level with APB configuration registers.
// Depends on dwnp_pkg and the channel interfaces in dwnp_ifs.
//
// Usage: send a start request (mode 0) with a pick point in top-left origin
// coordinates; the block answers with the clamped window origin (bottom-left
// origin). Then stream the WINDOW*WINDOW depth samples (mode 1) in raster
// order, columns first, rows from the bottom. After the last sample the block
// answers with found, the absolute hit coordinates and the hit depth.
// Channels: in_ch takes requests, out_ch gives results, both valid/ready.
// A request is held in the input register and its result then in the result
// register; a stalled out_ch can keep a request waiting in the input register.
// Throughput: one request per cycle unless a result-giving request waits for the
// result register; each sample's distance add and compare are combinational.
// Sample requests that give no result keep flowing while out_ch is stalled;
// a request that gives a result waits in the input register until the
// result register is free, and in_ch.ready drops only then.
// Reset (rst_n low, synchronous) empties both registers, sets the viewport
// to 400 x 400 and clears the window origin and the search state.
// Viewport registers: width at byte address 0, height at 4; write only idle.
`default_nettype none

module depth_window_nearest_pick #(
  parameter int unsigned WINDOW = dwnp_pkg::WINDOW_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  dwnp_in_if.sink                                  in_ch,
  dwnp_out_if.source                               out_ch,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [dwnp_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [dwnp_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [dwnp_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  localparam int unsigned CW   = $clog2(WINDOW);
  localparam int unsigned DW   = CW + 1;
  localparam int unsigned HALF = WINDOW / 2;
  localparam int unsigned CRW  = dwnp_pkg::COORD_W;

  localparam logic [CW-1:0] LAST_IDX = CW'(WINDOW - 1);
  localparam logic [CW-1:0] MID      = CW'(HALF);

  // configuration
  logic [CRW-1:0] vp_w_r, vp_w_nxt;
  logic [CRW-1:0] vp_h_r, vp_h_nxt;
  logic           cfg_wr;
  dwnp_pkg::reg_idx_t cfg_idx;

  // input register
  dwnp_pkg::in_item_t s1_r;
  logic               s1_valid_r, s1_valid_nxt;

  // search state
  logic [CRW-1:0] org_x_r, org_x_nxt;
  logic [CRW-1:0] org_y_r, org_y_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [CW-1:0]  row_r, row_nxt;
  logic [CW-1:0]  best_col_r, best_col_nxt;
  logic [CW-1:0]  best_row_r, best_row_nxt;
  logic [DW-1:0]  best_dist_r, best_dist_nxt;
  logic [dwnp_pkg::DEPTH_W-1:0] best_depth_r, best_depth_nxt;
  logic           hit_seen_r, hit_seen_nxt;

  // result register
  dwnp_pkg::out_item_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  // datapath
  logic                 is_start;
  logic                 is_last;
  logic                 has_res;
  logic                 s1_fire;
  logic signed [14:0]   flip_y;
  logic [CRW-1:0]       corner_x;
  logic [CRW-1:0]       corner_y;
  logic [CW-1:0]        off_c;
  logic [CW-1:0]        off_r;
  logic [DW-1:0]        span;
  logic                 take;
  logic [CW-1:0]        pick_col;
  logic [CW-1:0]        pick_row;
  logic [dwnp_pkg::DEPTH_W-1:0] pick_depth;
  logic                 pick_seen;

  // ---------------- APB ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = dwnp_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      dwnp_pkg::REG_VIEWPORT_WIDTH:  prdata = {{(dwnp_pkg::CFG_DATA_W-CRW){1'b0}}, vp_w_r};
      dwnp_pkg::REG_VIEWPORT_HEIGHT: prdata = {{(dwnp_pkg::CFG_DATA_W-CRW){1'b0}}, vp_h_r};
      default:                       prdata = '0;
    endcase
  end

  always_comb begin
    vp_w_nxt = vp_w_r;
    vp_h_nxt = vp_h_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        dwnp_pkg::REG_VIEWPORT_WIDTH:  vp_w_nxt = pwdata[CRW-1:0];
        dwnp_pkg::REG_VIEWPORT_HEIGHT: vp_h_nxt = pwdata[CRW-1:0];
        default: begin
          vp_w_nxt = vp_w_r;
          vp_h_nxt = vp_h_r;
        end
      endcase
    end
  end

  // ---------------- handshake ----------------
  assign is_start = (s1_r.mode == dwnp_pkg::MODE_START);
  assign is_last  = !is_start && (col_r == LAST_IDX) && (row_r == LAST_IDX);
  assign has_res  = is_start || is_last;
  assign s1_fire  = s1_valid_r && (!has_res || !out_valid_r || out_ch.ready);

  assign in_ch.ready  = !s1_valid_r || s1_fire;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // ---------------- start: flip and clamp ----------------
  assign flip_y   = $signed({2'b0, vp_h_r}) - 15'sd1 - $signed({2'b0, s1_r.point_y});
  assign corner_x = dwnp_pkg::place_corner($signed({2'b0, s1_r.point_x}), vp_w_r,
                                           6'(HALF), 7'(WINDOW));
  assign corner_y = dwnp_pkg::place_corner(flip_y, vp_h_r, 6'(HALF), 7'(WINDOW));

  // ---------------- sample: distance and compare ----------------
  assign off_c = (col_r >= MID) ? (col_r - MID) : (MID - col_r);
  assign off_r = (row_r >= MID) ? (row_r - MID) : (MID - row_r);
  assign span  = DW'(off_c) + DW'(off_r);
  assign take  = (s1_r.depth_sample != dwnp_pkg::DEPTH_EMPTY) && (span < best_dist_r);

  // best after this sample, used for the answer on the last one
  assign pick_col   = take ? col_r : best_col_r;
  assign pick_row   = take ? row_r : best_row_r;
  assign pick_depth = take ? s1_r.depth_sample : best_depth_r;
  assign pick_seen  = take || hit_seen_r;

  always_comb begin
    s1_valid_nxt   = s1_valid_r;
    org_x_nxt      = org_x_r;
    org_y_nxt      = org_y_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    best_col_nxt   = best_col_r;
    best_row_nxt   = best_row_r;
    best_dist_nxt  = best_dist_r;
    best_depth_nxt = best_depth_r;
    hit_seen_nxt   = hit_seen_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;

    if (in_ch.valid && in_ch.ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (s1_fire) begin
      if (is_start || is_last) begin
        // drop the search; a new window or a new pass begins
        col_nxt        = '0;
        row_nxt        = '0;
        best_col_nxt   = '0;
        best_row_nxt   = '0;
        best_dist_nxt  = '1;
        best_depth_nxt = '0;
        hit_seen_nxt   = 1'b0;
      end else begin
        if (take) begin
          best_col_nxt   = col_r;
          best_row_nxt   = row_r;
          best_dist_nxt  = span;
          best_depth_nxt = s1_r.depth_sample;
          hit_seen_nxt   = 1'b1;
        end
        if (col_r == LAST_IDX) begin
          col_nxt = '0;
          row_nxt = row_r + CW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end

      if (is_start) begin
        org_x_nxt     = corner_x;
        org_y_nxt     = corner_y;
        out_valid_nxt = 1'b1;
        out_nxt       = '{result_kind: dwnp_pkg::KIND_ORIGIN, window_x: corner_x,
                          window_y: corner_y, found: 1'b0, hit_x: '0, hit_y: '0,
                          hit_depth: '0};
      end else if (is_last) begin
        out_valid_nxt       = 1'b1;
        out_nxt.result_kind = dwnp_pkg::KIND_PICK;
        out_nxt.window_x    = org_x_r;
        out_nxt.window_y    = org_y_r;
        out_nxt.found       = pick_seen;
        out_nxt.hit_x       = pick_seen ? (org_x_r + CRW'(pick_col)) : '0;
        out_nxt.hit_y       = pick_seen ? (org_y_r + CRW'(pick_row)) : '0;
        out_nxt.hit_depth   = pick_seen ? pick_depth : '0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_w_r      <= dwnp_pkg::VP_WIDTH_RST;
      vp_h_r      <= dwnp_pkg::VP_HEIGHT_RST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      org_x_r     <= '0;
      org_y_r     <= '0;
      col_r       <= '0;
      row_r       <= '0;
      best_col_r  <= '0;
      best_row_r  <= '0;
      best_dist_r <= '1;
      best_depth_r <= '0;
      hit_seen_r  <= 1'b0;
    end else begin
      vp_w_r      <= vp_w_nxt;
      vp_h_r      <= vp_h_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      org_x_r     <= org_x_nxt;
      org_y_r     <= org_y_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      best_col_r  <= best_col_nxt;
      best_row_r  <= best_row_nxt;
      best_dist_r <= best_dist_nxt;
      best_depth_r <= best_depth_nxt;
      hit_seen_r  <= hit_seen_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_r <= in_ch.data;
    end
    out_r <= out_nxt;
  end

  // ---------------- assertions ----------------
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && is_start) |=> (col_r == '0 && row_r == '0 && !hit_seen_r))
    else $error("start request did not clear the search");

  a_seen_matches_dist: assert property (@(posedge clk) disable iff (!rst_n)
    hit_seen_r == (best_dist_r != '1))
    else $error("hit flag and best distance disagree");

  a_counters_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= LAST_IDX) && (row_r <= LAST_IDX))
    else $error("window counters out of range");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire && has_res))
    else $error("result shown without a request that makes one");

endmodule

`default_nettype wire
